// ===== rtl/twn_pkg.sv =====
// Shared types, constants and helpers for the text whitespace normalizer.
// No dependencies; every other file uses this package by scoped names.
package twn_pkg;

    localparam int LenBits  = 12;
    localparam int CapW     = 12;
    localparam int LenOutW  = 12;
    localparam int ResMax   = 4;
    localparam int CntW     = 3;
    localparam int PaddrW   = 3;
    localparam int DataW    = 32;

    localparam logic [7:0] Mark0   = 8'hE2;
    localparam logic [7:0] Mark1   = 8'h96;
    localparam logic [7:0] Mark2   = 8'h81;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] CaseOff = 8'h20;

    localparam logic [CapW-1:0]   CapReset  = 12'd4095;
    localparam logic [PaddrW-1:0] AddrOutCapacity = 3'd0;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_EOL  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          out_byte;
        logic [LenOutW-1:0]  line_length;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                    load;
        logic [CntW-1:0]         cnt;
        t_result [ResMax-1:0]    res;
    } t_batch;

    function automatic t_result make_byte(input logic [7:0] b);
        t_result r;
        r.kind        = KIND_BYTE;
        r.out_byte    = b;
        r.line_length = '0;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_result make_report(input logic [LenOutW-1:0] len);
        t_result r;
        r.kind        = KIND_REPORT;
        r.out_byte    = '0;
        r.line_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/twn_cfg.sv =====
// APB-style configuration register holding the per-line output capacity.
// Depends on twn_pkg.
module twn_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twn_pkg::PaddrW-1:0]  paddr,
    input  logic [twn_pkg::DataW-1:0]   pwdata,
    output logic [twn_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output logic [twn_pkg::CapW-1:0]    o_capacity
);

    logic [twn_pkg::CapW-1:0] r_capacity;
    logic                     wr_cap;

    assign pready = 1'b1;
    assign wr_cap = psel && penable && pwrite && (paddr == twn_pkg::AddrOutCapacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= twn_pkg::CapReset;
        end else if (wr_cap) begin
            r_capacity <= pwdata[twn_pkg::CapW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == twn_pkg::AddrOutCapacity) begin
            prdata = twn_pkg::DataW'(r_capacity);
        end
    end

    assign o_capacity = r_capacity;

endmodule

// ===== rtl/twn_core.sv =====
// Input word register, line state and single-pass normalization logic.
// Produces up to four results per word as a batch; depends on twn_pkg.
module twn_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [7:0]                  i_in_byte,
    input  logic [twn_pkg::CapW-1:0]    i_capacity,
    input  logic                        i_buf_free,
    output twn_pkg::t_batch             o_batch
);

    localparam int CmpW = (twn_pkg::LenBits > twn_pkg::CapW) ? twn_pkg::LenBits
                                                               : twn_pkg::CapW;

    logic                           r_in_valid;
    logic                           r_command;
    logic [7:0]                     r_in_byte;

    logic                           r_after_space;
    logic [twn_pkg::LenBits-1:0]    r_wc;
    logic                           r_stopped;
    logic [2:0][7:0]                r_hb;
    logic [1:0]                     r_fill;

    logic                           n_after_space;
    logic [twn_pkg::LenBits-1:0]    n_wc;
    logic                           n_stopped;
    logic [2:0][7:0]                n_hb;
    logic [1:0]                     n_fill;

    logic                           fire;
    logic                           eol;
    logic                           ws;
    logic                           marker_held;
    logic [7:0]                     lc;
    logic [CmpW-1:0]                cap_ext;
    logic [CmpW-1:0]                mask_ext;
    logic [CmpW-1:0]                cap_eff;
    logic [CmpW-1:0]                wc_ext;
    logic [CmpW-1:0]                room;
    logic [twn_pkg::CntW-1:0]       cnt;
    twn_pkg::t_batch                batch;

    assign fire       = r_in_valid && i_buf_free;
    assign o_in_stall = r_in_valid && !i_buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_command <= i_command;
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_space <= 1'b1;
            r_wc          <= '0;
            r_stopped     <= 1'b0;
            r_fill        <= '0;
        end else if (fire) begin
            r_after_space <= n_after_space;
            r_wc          <= n_wc;
            r_stopped     <= n_stopped;
            r_fill        <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_hb <= n_hb;
        end
    end

    assign eol = (r_command == twn_pkg::CMD_EOL) || (r_in_byte == 8'h00);
    assign ws  = (r_in_byte == twn_pkg::ChSpace) || (r_in_byte == twn_pkg::ChTab) ||
                 (r_in_byte == twn_pkg::ChLf) || (r_in_byte == twn_pkg::ChCr);
    assign marker_held = (r_fill == 2'd3) && (r_hb[0] == twn_pkg::Mark0) &&
                         (r_hb[1] == twn_pkg::Mark1) && (r_hb[2] == twn_pkg::Mark2);

    assign cap_ext  = CmpW'(i_capacity);
    assign mask_ext = CmpW'({twn_pkg::LenBits{1'b1}});
    assign cap_eff  = (cap_ext < mask_ext) ? cap_ext : mask_ext;
    assign wc_ext   = CmpW'(r_wc);
    assign room     = cap_eff - wc_ext;

    always_comb begin
        lc = r_in_byte;
        if (r_in_byte inside {[twn_pkg::ChUpA:twn_pkg::ChUpZ]}) begin
            lc = r_in_byte + twn_pkg::CaseOff;
        end
    end

    always_comb begin
        n_after_space = r_after_space;
        n_wc          = r_wc;
        n_stopped     = r_stopped;
        n_hb          = r_hb;
        n_fill        = r_fill;
        cnt           = '0;
        batch         = '0;
        batch.load    = fire;
        if (eol) begin
            if (marker_held) begin
                batch.res[0] = twn_pkg::make_report(
                    twn_pkg::LenOutW'(r_wc - twn_pkg::LenBits'(3)));
                cnt = twn_pkg::CntW'(1);
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_fill) begin
                        batch.res[i] = twn_pkg::make_byte(r_hb[i]);
                    end
                end
                batch.res[r_fill] = twn_pkg::make_report(twn_pkg::LenOutW'(r_wc));
                cnt = twn_pkg::CntW'(r_fill) + twn_pkg::CntW'(1);
            end
            n_after_space = 1'b1;
            n_wc          = '0;
            n_stopped     = 1'b0;
            n_fill        = '0;
        end else if (!r_stopped && (wc_ext < cap_eff)) begin
            if (ws) begin
                if (!r_after_space) begin
                    if (room < CmpW'(3)) begin
                        n_stopped = 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (2'(i) < r_fill) begin
                                batch.res[i] = twn_pkg::make_byte(r_hb[i]);
                            end
                        end
                        cnt           = twn_pkg::CntW'(r_fill);
                        n_hb[0]       = twn_pkg::Mark0;
                        n_hb[1]       = twn_pkg::Mark1;
                        n_hb[2]       = twn_pkg::Mark2;
                        n_fill        = 2'd3;
                        n_wc          = r_wc + twn_pkg::LenBits'(3);
                        n_after_space = 1'b1;
                    end
                end
            end else begin
                if (r_fill == 2'd3) begin
                    batch.res[0] = twn_pkg::make_byte(r_hb[0]);
                    cnt          = twn_pkg::CntW'(1);
                    n_hb[0]      = r_hb[1];
                    n_hb[1]      = r_hb[2];
                    n_hb[2]      = lc;
                end else begin
                    n_hb[r_fill] = lc;
                    n_fill       = r_fill + 2'd1;
                end
                n_wc          = r_wc + twn_pkg::LenBits'(1);
                n_after_space = 1'b0;
            end
        end
        if (cnt != '0) begin
            batch.res[2'(cnt - twn_pkg::CntW'(1))].last = 1'b1;
        end
        batch.cnt = cnt;
    end

    assign o_batch = batch;

`ifndef ASSERT_OFF
    a_eol_restarts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && eol |=> (r_fill == 2'd0) && (r_wc == '0) && r_after_space && !r_stopped)
        else $error("line state not cleared after end of line");

    a_space_holds_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_after_space && (r_fill != 2'd0) |->
            (r_hb[0] == twn_pkg::Mark0) && (r_hb[1] == twn_pkg::Mark1) &&
            (r_hb[2] == twn_pkg::Mark2))
        else $error("holdback does not end in a marker after whitespace");

    a_stop_after_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !r_after_space)
        else $error("stopped set without preceding text");

    a_fill_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        twn_pkg::LenBits'(r_fill) <= r_wc)
        else $error("holdback fill exceeds written count");
`endif

endmodule

// ===== rtl/twn_outbuf.sv =====
// Result register: holds one batch of up to four results and drains one per cycle
// while i_out_stall is low. Depends on twn_pkg.
module twn_outbuf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twn_pkg::t_batch               i_batch,
    output logic                          o_buf_free,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_item_kind,
    output logic [7:0]                    o_out_byte,
    output logic [twn_pkg::LenOutW-1:0]   o_line_length,
    output logic                          o_last_of_run
);

    logic [twn_pkg::CntW-1:0]                r_cnt;
    twn_pkg::t_result [twn_pkg::ResMax-1:0]  r_slot;
    logic                                    pop;

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_buf_free  = (r_cnt == '0) || ((r_cnt == twn_pkg::CntW'(1)) && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_batch.load) begin
            r_cnt <= i_batch.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - twn_pkg::CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_batch.load) begin
            r_slot <= i_batch.res;
        end else if (pop) begin
            for (int i = 0; i < twn_pkg::ResMax - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    assign o_item_kind   = r_slot[0].kind;
    assign o_out_byte    = r_slot[0].out_byte;
    assign o_line_length = r_slot[0].line_length;
    assign o_last_of_run = r_slot[0].last;

`ifndef ASSERT_OFF
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_batch.load |-> o_buf_free)
        else $error("batch loaded over undelivered results");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= twn_pkg::CntW'(twn_pkg::ResMax))
        else $error("result count out of range");

    a_last_closes_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && o_last_of_run && !i_batch.load |=> (r_cnt == '0))
        else $error("results remain after last of run");
`endif

endmodule

// ===== rtl/text_whitespace_normalizer_unit.sv =====
// Top level of the text whitespace normalizer: config register, core, result buffer.
// Depends on twn_pkg, twn_cfg, twn_core and twn_outbuf.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------------
//   input    | in        | i_in_valid / o_in_stall | i_command, i_in_byte
//   output   | out       | o_out_valid/ i_out_stall| o_item_kind, o_out_byte,
//            |           |                         | o_line_length, o_last_of_run
//   config   | in/out    | APB psel/penable/pready | paddr, pwdata, prdata
//
// A word waits in the input register until the result register is free; its results
// (zero to four) then move into the result register together and leave one per cycle
// while i_out_stall is low. Sustained rate is one word per cycle if each word yields at
// most one result and i_out_stall is low; more results hold the register till all leave.
// Reset: out_capacity = 4095, line state cleared; no clearing pass.
// o_in_stall rises when the input register holds a word and the result register
// still has undelivered results beyond the one leaving this cycle.
module text_whitespace_normalizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [7:0]                    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_item_kind,
    output logic [7:0]                    o_out_byte,
    output logic [twn_pkg::LenOutW-1:0]   o_line_length,
    output logic                          o_last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twn_pkg::PaddrW-1:0]    paddr,
    input  logic [twn_pkg::DataW-1:0]     pwdata,
    output logic [twn_pkg::DataW-1:0]     prdata,
    output logic                          pready
);

    logic [twn_pkg::CapW-1:0] capacity;
    logic                     buf_free;
    twn_pkg::t_batch          batch;

    twn_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    twn_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_in_byte  (i_in_byte),
        .i_capacity (capacity),
        .i_buf_free (buf_free),
        .o_batch    (batch)
    );

    twn_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch       (batch),
        .o_buf_free    (buf_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_item_kind   (o_item_kind),
        .o_out_byte    (o_out_byte),
        .o_line_length (o_line_length),
        .o_last_of_run (o_last_of_run)
    );

endmodule
